### rtl/core/wspe_pkg.sv
// ----------------------------------------------------------------------------
// wspe_pkg
// shared types for the word sparse pack encoder: the queue entry that carries
// one encoded word from the front part to the back part
// ----------------------------------------------------------------------------
package wspe_pkg;

  localparam int unsigned MaxBytes = 9;
  localparam int unsigned CountW   = 4;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CountW-1:0]        count;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### rtl/core/wspe_front.sv
// ----------------------------------------------------------------------------
// wspe_front
// accepts one word per request, classifies it and builds its encoded bytes:
// raw pass-through, small value, index list or byte map
// ----------------------------------------------------------------------------
module wspe_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [63:0]       word_value,
  input  logic [1:0]        width_code,
  input  wspe_pkg::q_status_t q_status,
  output logic              busy,
  output logic              push,
  output wspe_pkg::entry_t  push_data
);
  import wspe_pkg::*;

  localparam logic [1:0] CODE_BYTE  = 2'd0;
  localparam logic [1:0] CODE_HALF  = 2'd1;
  localparam logic [1:0] CODE_WORD  = 2'd2;
  localparam logic [1:0] CODE_DWORD = 2'd3;

  typedef enum logic [2:0] {F_IDLE, F_COUNT, F_CLASS, F_INDEX, F_PUSH} state_t;

  function automatic logic [63:0] width_mask(input logic [1:0] c);
    logic [63:0] m;
    case (c)
      CODE_BYTE:  m = 64'h0000_0000_0000_00ff;
      CODE_HALF:  m = 64'h0000_0000_0000_ffff;
      CODE_WORD:  m = 64'h0000_0000_ffff_ffff;
      default:    m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] highest(input logic [63:0] v);
    logic [5:0] h;
    h = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) h = 6'(i);
    end
    return h;
  endfunction

  function automatic logic [2:0] field_width(input logic [5:0] p);
    logic [2:0] w;
    if (p < 6'd2)       w = 3'd1;
    else if (p < 6'd4)  w = 3'd2;
    else if (p < 6'd8)  w = 3'd3;
    else if (p < 6'd16) w = 3'd4;
    else if (p < 6'd32) w = 3'd5;
    else                w = 3'd6;
    return w;
  endfunction

  state_t      state;
  logic [63:0] u;
  logic [1:0]  code;
  logic        inv;
  logic [6:0]  sum;
  logic [63:0] rem;
  logic [31:0] acc;
  logic [4:0]  pos;
  logic [2:0]  fw;
  logic [5:0]  prev;
  logic        first;
  entry_t      ent;

  // count stage
  logic [6:0]  pc;
  logic [6:0]  half_bits;
  logic        inv_c;
  logic [63:0] u_flip;
  logic [6:0]  sum_c;

  always_comb begin
    pc        = 7'($countones(u));
    half_bits = (code == CODE_DWORD) ? 7'd32 : 7'd16;
    inv_c     = pc > half_bits;
    u_flip    = inv_c ? (~u & width_mask(code)) : u;
    sum_c     = inv_c ? 7'((half_bits << 1) - pc) : pc;
  end

  // byte map form
  logic [7:0] bmap;
  logic       partial;
  entry_t     map_ent;

  always_comb begin
    logic [3:0] j;
    for (int k = 0; k < 8; k++) begin
      bmap[k] = |u[8*k +: 8];
    end
    partial = (code == CODE_DWORD) ? (bmap != 8'hff) : (bmap[3:0] != 4'hf);
    map_ent.bytes    = '0;
    map_ent.bytes[0] = {partial ? bmap[3:0] : 4'h0, partial, 1'b1, 1'b1, inv};
    j = 4'd1;
    if (partial && code == CODE_DWORD) begin
      map_ent.bytes[1] = {4'h0, bmap[7:4]};
      j = 4'd2;
    end
    for (int k = 0; k < 8; k++) begin
      if (bmap[k]) begin
        map_ent.bytes[j] = u[8*k +: 8];
        j = j + 4'd1;
      end
    end
    map_ent.count = j;
  end

  // index list step
  logic [5:0] hi;
  logic [5:0] delta;
  logic [6:0] endpos;
  logic [3:0] nbytes;

  always_comb begin
    hi     = highest(rem);
    delta  = first ? hi : 6'(prev - hi);
    endpos = 7'(pos) + 7'(fw);
    nbytes = 4'((endpos + 7'd7) >> 3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (start) begin
            u     <= word_value & width_mask(width_code);
            code  <= width_code;
            state <= F_COUNT;
          end
        end
        F_COUNT: begin
          if (code == CODE_BYTE || code == CODE_HALF) begin
            ent.bytes <= 72'(u[15:0]);
            ent.count <= (code == CODE_BYTE) ? 4'd1 : 4'd2;
            state     <= F_PUSH;
          end else begin
            u     <= u_flip;
            inv   <= inv_c;
            sum   <= sum_c;
            state <= F_CLASS;
          end
        end
        F_CLASS: begin
          if (u < 64'd64) begin
            ent.bytes <= 72'({u[5:0], 1'b0, inv});
            ent.count <= 4'd1;
            state     <= F_PUSH;
          end else if (sum < 7'd4) begin
            rem   <= u;
            acc   <= {30'b0, 1'b1, inv};
            pos   <= 5'd3;
            fw    <= (code == CODE_DWORD) ? 3'd6 : 3'd5;
            prev  <= 6'd0;
            first <= 1'b1;
            state <= F_INDEX;
          end else begin
            ent   <= map_ent;
            state <= F_PUSH;
          end
        end
        F_INDEX: begin
          if (rem != 64'd0) begin
            acc      <= acc | (32'(delta) << pos);
            pos      <= pos + 5'(fw);
            fw       <= field_width(hi);
            prev     <= hi;
            first    <= 1'b0;
            rem[hi]  <= 1'b0;
          end else begin
            ent.bytes <= 72'(acc);
            ent.count <= nbytes;
            state     <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_status.full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign busy      = (state != F_IDLE);
  assign push      = (state == F_PUSH) && !q_status.full;
  assign push_data = ent;

endmodule

### rtl/core/wspe_queue.sv
// ----------------------------------------------------------------------------
// wspe_queue
// two-entry queue of encoded words between the front and back parts
// ----------------------------------------------------------------------------
module wspe_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  wspe_pkg::entry_t   push_data,
  input  logic               pop,
  output wspe_pkg::entry_t   pop_data,
  output wspe_pkg::q_status_t status
);
  import wspe_pkg::*;

  entry_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= 2'(fill + {1'b0, push} - {1'b0, pop});
    end
  end

  assign pop_data     = mem[rd_ptr];
  assign status.full  = (fill == 2'd2);
  assign status.empty = (fill == 2'd0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty) else $error("pop from empty queue");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3) else $error("queue fill out of range");

endmodule

### rtl/core/wspe_back.sv
// ----------------------------------------------------------------------------
// wspe_back
// takes encoded words from the queue and sends them out one byte per cycle
// ----------------------------------------------------------------------------
module wspe_back (
  input  logic                clk,
  input  logic                rst,
  input  wspe_pkg::q_status_t q_status,
  input  wspe_pkg::entry_t    q_data,
  output logic                pop,
  output logic                strobe,
  output logic [7:0]          out_byte,
  output logic                last_byte
);
  import wspe_pkg::*;

  logic       have;
  entry_t     cur;
  logic [3:0] idx;
  logic       is_last;

  assign is_last = (idx == 4'(cur.count - 4'd1));
  assign pop     = !q_status.empty && (!have || is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      have   <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= have;
      if (have) begin
        out_byte  <= cur.bytes[idx];
        last_byte <= is_last;
      end
      if (pop) begin
        cur  <= q_data;
        idx  <= 4'd0;
        have <= 1'b1;
      end else if (have) begin
        idx <= idx + 4'd1;
        if (is_last) have <= 1'b0;
      end
    end
  end

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_byte |-> have) else $error("gap inside a word");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    have |-> idx < cur.count) else $error("byte index past word length");

endmodule

### rtl/core/word_sparse_pack_encoder.sv
// ----------------------------------------------------------------------------
// word_sparse_pack_encoder
// encodes one word per request into a short little-endian byte stream
// ----------------------------------------------------------------------------
// usage:
//   a request is taken at a clock edge with start high and busy low; it
//   carries word_value and width_code (0/1 raw 1 or 2 bytes, 2/3 compressed
//   32 or 64 bit word).
//   each encoded byte appears on out_byte for one cycle with strobe high;
//   last_byte marks the final byte of a word. 1 to 9 bytes per word.
// throughput: the front steps through its states for each word (one step per
//   set bit of an index list) and waits while the queue is full; the back
//   sends one byte a cycle, with no gap between words while the queue holds
//   the next word.
//   a two-entry queue between them lets the front run ahead of the output.
// reset: rst is synchronous; it drops busy and strobe and empties the queue.
// the receiver cannot stall: every strobe is a delivered byte.
// ----------------------------------------------------------------------------
module word_sparse_pack_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] word_value,
  input  logic [1:0]  width_code,
  output logic        strobe,
  output logic [7:0]  out_byte,
  output logic        last_byte
);
  import wspe_pkg::*;

  logic      push;
  entry_t    push_data;
  logic      pop;
  entry_t    pop_data;
  q_status_t q_status;

  wspe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .word_value (word_value),
    .width_code (width_code),
    .q_status   (q_status),
    .busy       (busy),
    .push       (push),
    .push_data  (push_data)
  );

  wspe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  wspe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_data    (pop_data),
    .pop       (pop),
    .strobe    (strobe),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request not taken up");

endmodule

### tb/word_sparse_pack_encoder_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_sparse_pack_encoder_chk
// watches the request and byte channels of the encoder, predicts the encoded
// byte stream of every accepted request and compares each strobed byte with
// the oldest predicted one; hands the mismatch count and the number of bytes
// still due to the testbench top
// ----------------------------------------------------------------------------
package wspe_tb_pkg;

  typedef enum logic [1:0] {
    WidthByte   = 2'd0,
    WidthHalf   = 2'd1,
    WidthWord   = 2'd2,
    WidthDouble = 2'd3
  } width_code_e;

  localparam logic [7:0] HdrInverted = 8'h01;
  localparam logic [7:0] HdrPacked   = 8'h02;
  localparam logic [7:0] HdrByteMap  = 8'h04;
  localparam logic [7:0] HdrPartial  = 8'h08;
  localparam int         SmallLimit  = 64;
  localparam int         IndexLimit  = 4;
  localparam int         MaxBytes    = 9;

endpackage

module word_sparse_pack_encoder_chk
  import wspe_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] word_value,
  input  logic [1:0]  width_code,
  input  logic        strobe,
  input  logic [7:0]  out_byte,
  input  logic        last_byte,
  output int          fails,
  output int          pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } enc_byte_t;

  enc_byte_t due_bytes[$];

  function automatic int delta_width(input int p);
    if (p < 2) return 1;
    if (p < 4) return 2;
    if (p < 8) return 3;
    if (p < 16) return 4;
    if (p < 32) return 5;
    return 6;
  endfunction

  task automatic encode_word(input logic [63:0] v, input logic [1:0] code,
                             output logic [MaxBytes-1:0][7:0] b, output int n);
    int bits, lg, ones, pos, w, prev, nb, j;
    logic inv, first;
    logic [63:0] mask, u, acc;
    logic [7:0] map, full;
    b = '0;
    n = 0;
    case (code)
      WidthByte: begin
        b[0] = v[7:0];
        n = 1;
      end
      WidthHalf: begin
        b[0] = v[7:0];
        b[1] = v[15:8];
        n = 2;
      end
      default: begin
        lg = (code == WidthWord) ? 5 : 6;
        bits = 1 << lg;
        mask = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
        u = v & mask;
        ones = $countones(u);
        inv = 1'b0;
        if (ones > bits / 2) begin
          inv = 1'b1;
          ones = bits - ones;
          u = ~u & mask;
        end
        if (u < SmallLimit) begin
          b[0] = {u[5:0], 1'b0, inv};
          n = 1;
        end else if (ones < IndexLimit) begin
          // highest position, then downward deltas, then a zero end field
          acc = '0;
          acc[7:0] = HdrPacked | (inv ? HdrInverted : 8'h00);
          pos = 3;
          w = lg;
          first = 1'b1;
          prev = 0;
          for (int i = bits - 1; i >= 0; i--) begin
            if (u[i]) begin
              acc = acc | ((first ? 64'(i) : 64'(prev - i)) << pos);
              first = 1'b0;
              pos = pos + w;
              w = delta_width(i);
              prev = i;
            end
          end
          pos = pos + w;
          n = (pos + 7) / 8;
          for (int k = 0; k < n; k++) b[k] = acc[8*k +: 8];
        end else begin
          nb = bits / 8;
          map = '0;
          full = (nb == 8) ? 8'hFF : 8'h0F;
          for (int k = 0; k < nb; k++) if (u[8*k +: 8] != 8'd0) map[k] = 1'b1;
          b[0] = HdrPacked | HdrByteMap | (inv ? HdrInverted : 8'h00);
          j = 0;
          if (map != full) begin
            b[0] = b[0] | HdrPartial | {map[3:0], 4'h0};
            if (nb > 4) begin
              j++;
              b[j] = {4'h0, map[7:4]};
            end
          end
          for (int k = 0; k < nb; k++) begin
            if (u[8*k +: 8] != 8'd0) begin
              j++;
              b[j] = u[8*k +: 8];
            end
          end
          n = j + 1;
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("%0t: mismatch on %s: got %02h, expected %02h", $realtime, what, got, want);
    fails++;
  endtask

  always @(posedge clk) begin : watch
    logic [MaxBytes-1:0][7:0] pred;
    int cnt;
    enc_byte_t want;
    if (rst) begin
      due_bytes.delete();
      fails = 0;
    end else begin
      if (strobe) begin
        if (due_bytes.size() == 0) begin
          report_mismatch("unexpected byte", out_byte, 8'h00);
        end else begin
          want = due_bytes.pop_front();
          if (out_byte !== want.data) report_mismatch("out_byte", out_byte, want.data);
          if (last_byte !== want.last) begin
            report_mismatch("last_byte", {7'd0, last_byte}, {7'd0, want.last});
          end
        end
      end
      if (start && !busy) begin
        encode_word(word_value, width_code, pred, cnt);
        for (int k = 0; k < cnt; k++) due_bytes.push_back({pred[k], k == cnt - 1});
      end
    end
    pending <= due_bytes.size();
  end

endmodule

### tb/word_sparse_pack_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_sparse_pack_encoder_tb
// drives the encoder with a directed set of words covering raw sizes, small
// values, index lists, byte maps, inversion and ignored high bits, then with
// bursts of random requests shaped toward each encoding form; a checker
// beside the block predicts and compares every byte
// ----------------------------------------------------------------------------
module word_sparse_pack_encoder_tb;
  import wspe_tb_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 20;
  localparam int RandomItems = 330;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [63:0] word_value = '0;
  logic [1:0]  width_code = WidthByte;
  logic        busy;
  logic        strobe;
  logic [7:0]  out_byte;
  logic        last_byte;
  int          fails;
  int          pending;
  int          cycles = 0;

  always #5 clk = ~clk;

  word_sparse_pack_encoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .word_value(word_value),
    .width_code(width_code),
    .strobe    (strobe),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

  word_sparse_pack_encoder_chk i_chk (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .word_value(word_value),
    .width_code(width_code),
    .strobe    (strobe),
    .out_byte  (out_byte),
    .last_byte (last_byte),
    .fails     (fails),
    .pending   (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("** word_sparse_pack_encoder: FAILED **");
      $finish;
    end
  end

  task automatic send_word(input logic [63:0] v, input width_code_e code);
    start <= 1'b1;
    word_value <= v;
    width_code <= code;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] random_word(input width_code_e code);
    logic [63:0] r, s, mask;
    int bits, kind;
    r = {$urandom, $urandom};
    s = '0;
    bits = (code == WidthWord) ? 32 : 64;
    mask = (bits == 64) ? '1 : 64'h0000_0000_FFFF_FFFF;
    kind = $urandom_range(0, 7);
    if (code == WidthByte || code == WidthHalf) return r;
    case (kind)
      1, 2: begin
        // sparse word, or its dense complement
        repeat ($urandom_range(1, 3)) s[$urandom_range(0, bits - 1)] = 1'b1;
        if (kind == 2) s = ~s & mask;
      end
      3: s = 64'($urandom_range(0, 63));
      4: s = ~64'($urandom_range(0, 63)) & mask;
      5: begin
        for (int k = 0; k < bits / 8; k++) if ($urandom_range(0, 1)) s[8*k +: 8] = r[8*k +: 8];
      end
      6: begin
        for (int k = 0; k < bits / 8; k++) s[8*k +: 8] = 8'($urandom_range(1, 255));
      end
      default: s = r & mask;
    endcase
    return (r & ~mask) | (s & mask);
  endfunction

  initial begin : stimulus
    int items, burst;
    width_code_e code;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // raw sizes, high bits ignored
    send_word(64'hDEAD_BEEF_CAFE_1200, WidthByte);
    send_word(64'h0000_0000_0000_00FF, WidthByte);
    send_word(64'hFFFF_FFFF_FFFF_0000, WidthHalf);
    send_word(64'h0000_0000_0000_FFFF, WidthHalf);
    send_word(64'h1234_5678_9ABC_A55A, WidthHalf);
    // 32-bit forms
    send_word(64'h0000_0000_0000_0000, WidthWord);
    send_word(64'hFFFF_FFFF_0000_003F, WidthWord);
    send_word(64'h0000_0000_0000_0040, WidthWord);
    send_word(64'h0000_0000_FFFF_FFFF, WidthWord);
    send_word(64'h0000_0000_FFFF_FFC0, WidthWord);
    send_word(64'h0000_0000_8000_0000, WidthWord);
    send_word(64'h1234_5678_8000_8001, WidthWord);
    send_word(64'h0000_0000_00FF_00FF, WidthWord);
    send_word(64'h0000_0000_0101_0101, WidthWord);
    send_word(64'h0000_0000_7FFF_7FFE, WidthWord);
    hold_off(3);
    // 64-bit forms
    send_word(64'h0000_0000_0000_0000, WidthDouble);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, WidthDouble);
    send_word(64'h8000_0000_0000_0000, WidthDouble);
    send_word(64'hE000_0000_0000_0000, WidthDouble);
    send_word(64'h8000_0001_0000_0001, WidthDouble);
    send_word(64'h7FFF_FFFF_FFFF_FFFE, WidthDouble);
    send_word(64'h0101_0101_0101_0101, WidthDouble);
    send_word(64'hFF00_FF00_FF00_FF00, WidthDouble);
    send_word(64'h0000_0000_0000_00FF, WidthDouble);
    send_word(64'h8F00_0000_0000_00C0, WidthDouble);
    wait_drained();

    items = 0;
    while (items < RandomItems) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++) begin
        case ($urandom_range(0, 9))
          0: code = WidthByte;
          1: code = WidthHalf;
          2, 3, 4, 5: code = WidthWord;
          default: code = WidthDouble;
        endcase
        send_word(random_word(code), code);
        items++;
      end
      if (items >= RandomItems / 2 && items - burst < RandomItems / 2) begin
        wait_drained();
      end else if ($urandom_range(0, 3) != 0) begin
        hold_off($urandom_range(1, 8));
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("** word_sparse_pack_encoder: PASSED **");
    end else begin
      $display("** word_sparse_pack_encoder: FAILED **");
    end
    $finish;
  end

endmodule
